// ----- hw/rtl/pfa_pkg.sv -----
package pfa_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // fit strategy codes
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // register select, taken from paddr[2]
  localparam logic REG_FIT_STRATEGY = 1'b0;
  localparam logic REG_HOLE_COUNT   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } pfa_state_t;

  // control flags that travel with a probe along the cell chain
  typedef struct packed {
    logic active;
    logic alloc;
    logic rd;
    logic found;
    logic rd_occ;
  } pfa_probe_t;

endpackage

// ----- hw/rtl/pfa_cell.sv -----
module pfa_cell import pfa_pkg::*; #(
  parameter int SIZE_BITS  = 16,
  parameter int TAG_BITS   = 8,
  parameter int IDX_BITS   = 4,
  parameter int LIM_BITS   = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           strategy,
  input  logic [LIM_BITS-1:0]  limit,
  input  logic                 load_en,
  input  logic [IDX_BITS-1:0]  load_idx,
  input  logic [SIZE_BITS-1:0] load_cap,
  input  logic                 grant_en,
  input  logic [IDX_BITS-1:0]  grant_idx,
  input  logic [TAG_BITS-1:0]  grant_tag,
  input  pfa_probe_t           probe_in,
  input  logic [SIZE_BITS-1:0] size_in,
  input  logic [IDX_BITS-1:0]  target_in,
  input  logic [IDX_BITS-1:0]  best_idx_in,
  input  logic [SIZE_BITS-1:0] best_cap_in,
  input  logic [TAG_BITS-1:0]  owner_in,
  output pfa_probe_t           probe_out,
  output logic [SIZE_BITS-1:0] size_out,
  output logic [IDX_BITS-1:0]  target_out,
  output logic [IDX_BITS-1:0]  best_idx_out,
  output logic [SIZE_BITS-1:0] best_cap_out,
  output logic [TAG_BITS-1:0]  owner_out
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

  // hole state
  logic [SIZE_BITS-1:0] cap;
  logic                 occ;
  logic [TAG_BITS-1:0]  owner;

  logic       enabled;
  logic       fits;
  logic       take;
  logic       hit;
  pfa_probe_t probe_next;

  always_comb begin
    enabled = 32'(limit) > CELL_INDEX;
    fits    = probe_in.alloc && enabled && !occ && (cap >= size_in);
    hit     = probe_in.rd && (target_in == MY_IDX);
    unique case (strategy)
      FIT_FIRST: take = fits && !probe_in.found;
      FIT_BEST:  take = fits && (!probe_in.found || cap < best_cap_in);
      FIT_WORST: take = fits && (!probe_in.found || cap > best_cap_in);
      default:   take = 1'b0;
    endcase
    probe_next        = probe_in;
    probe_next.found  = probe_in.found || take;
    probe_next.rd_occ = hit ? occ : probe_in.rd_occ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
      occ <= 1'b0;
    end else if (load_en && load_idx == MY_IDX) begin
      cap <= load_cap;
      occ <= 1'b0;
    end else if (grant_en && grant_idx == MY_IDX) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (grant_en && grant_idx == MY_IDX) begin
      owner <= grant_tag;
    end
  end

  // probe stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    size_out     <= size_in;
    target_out   <= target_in;
    best_idx_out <= take ? MY_IDX : best_idx_in;
    best_cap_out <= (take || hit) ? cap : best_cap_in;
    if (hit) begin
      owner_out <= occ ? owner : '0;
    end else begin
      owner_out <= owner_in;
    end
  end

endmodule

// ----- hw/rtl/partition_fit_allocator.sv -----
// partition fit allocator: a table of fixed memory holes, one per cell of a chain
// input channel: in_valid / in_stall with cmd, hole_index, hole_capacity,
//   request_size, request_tag; a word is taken when in_valid is high and in_stall low
// output channel: out_valid / out_stall; exactly one result word per input word
// load writes a hole's capacity and frees it, allocate picks a free hole by the
//   configured strategy (first, best, worst fit), read reports one hole's status
// every command sends one probe down the chain, one cell per cycle, through the
//   cell registers to the result register and then the output register; the next
//   word is taken in the cycle after the result moves to the output register,
//   so no new word is taken while one is still in the chain
// a grant is written into the chosen cell as the probe leaves the chain
// the output register holds a result while out_stall is high; meanwhile the next
//   word is accepted and scanned, and it waits at the chain end until the slot frees
// reset: capacities and occupied flags clear, fit_strategy goes to first fit and
//   hole_count to 16; owner tags are only reported for occupied holes
// configuration: apb-style, fit_strategy at 0x0, hole_count at 0x4, write only
//   while idle; pready is always high
module partition_fit_allocator import pfa_pkg::*; #(
  parameter int HOLE_SLOTS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int TAG_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  hole_index,
  input  logic [15:0] hole_capacity,
  input  logic [15:0] request_size,
  input  logic [7:0]  request_tag,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        granted,
  output logic [3:0]  granted_hole,
  output logic        read_occupied,
  output logic [7:0]  read_owner,
  output logic [15:0] read_capacity
);

  localparam int IDX_BITS = (HOLE_SLOTS > 2) ? $clog2(HOLE_SLOTS) : 1;
  localparam int LIM_BITS = $clog2(HOLE_SLOTS + 1);

  // configuration registers
  logic [1:0] fit_strategy;
  logic [4:0] hole_count;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_strategy <= FIT_FIRST;
      hole_count   <= 5'd16;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_FIT_STRATEGY: fit_strategy <= pwdata[1:0];
        REG_HOLE_COUNT:   hole_count   <= pwdata[4:0];
        default:          fit_strategy <= fit_strategy;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIT_STRATEGY: prdata = {30'd0, fit_strategy};
      REG_HOLE_COUNT:   prdata = {27'd0, hole_count};
      default:          prdata = '0;
    endcase
  end

  // hole count saturates at the table size
  logic [LIM_BITS-1:0] limit;
  assign limit = (32'(hole_count) > HOLE_SLOTS) ? LIM_BITS'(HOLE_SLOTS)
                                                : LIM_BITS'(hole_count);

  // sequencer
  pfa_state_t state, state_next;
  logic       accept;
  logic       in_range;
  logic       out_free;
  logic       tail_done;

  pfa_probe_t           probe_chain    [0:HOLE_SLOTS];
  logic [SIZE_BITS-1:0] size_chain     [0:HOLE_SLOTS];
  logic [IDX_BITS-1:0]  target_chain   [0:HOLE_SLOTS];
  logic [IDX_BITS-1:0]  best_idx_chain [0:HOLE_SLOTS];
  logic [SIZE_BITS-1:0] best_cap_chain [0:HOLE_SLOTS];
  logic [TAG_BITS-1:0]  owner_chain    [0:HOLE_SLOTS];

  assign in_range  = 32'(hole_index) < HOLE_SLOTS;
  assign out_free  = !out_valid || !out_stall;
  assign tail_done = probe_chain[HOLE_SLOTS].active;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // tag of the allocate in flight
  logic [TAG_BITS-1:0] req_tag;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_tag <= TAG_BITS'(request_tag);
    end
  end

  // probe entering the first cell
  always_comb begin
    probe_chain[0]        = '0;
    probe_chain[0].active = accept;
    probe_chain[0].alloc  = accept && (cmd == CMD_ALLOC);
    probe_chain[0].rd     = accept && (cmd == CMD_READ) && in_range;
    size_chain[0]         = SIZE_BITS'(request_size);
    target_chain[0]       = IDX_BITS'(hole_index);
    best_idx_chain[0]     = '0;
    best_cap_chain[0]     = '0;
    owner_chain[0]        = '0;
  end

  logic                 load_en;
  logic                 grant_en;
  logic [IDX_BITS-1:0]  load_idx;
  logic [SIZE_BITS-1:0] load_cap;

  assign load_en  = accept && (cmd == CMD_LOAD) && in_range;
  assign load_idx = IDX_BITS'(hole_index);
  assign load_cap = SIZE_BITS'(hole_capacity);
  // the chosen hole is claimed as the probe leaves the chain
  assign grant_en = tail_done && probe_chain[HOLE_SLOTS].found;

  for (genvar k = 0; k < HOLE_SLOTS; k++) begin : g_cell
    pfa_cell #(
      .SIZE_BITS  (SIZE_BITS),
      .TAG_BITS   (TAG_BITS),
      .IDX_BITS   (IDX_BITS),
      .LIM_BITS   (LIM_BITS),
      .CELL_INDEX (k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .strategy     (fit_strategy),
      .limit        (limit),
      .load_en      (load_en),
      .load_idx     (load_idx),
      .load_cap     (load_cap),
      .grant_en     (grant_en),
      .grant_idx    (best_idx_chain[HOLE_SLOTS]),
      .grant_tag    (req_tag),
      .probe_in     (probe_chain[k]),
      .size_in      (size_chain[k]),
      .target_in    (target_chain[k]),
      .best_idx_in  (best_idx_chain[k]),
      .best_cap_in  (best_cap_chain[k]),
      .owner_in     (owner_chain[k]),
      .probe_out    (probe_chain[k+1]),
      .size_out     (size_chain[k+1]),
      .target_out   (target_chain[k+1]),
      .best_idx_out (best_idx_chain[k+1]),
      .best_cap_out (best_cap_chain[k+1]),
      .owner_out    (owner_chain[k+1])
    );
  end

  // result word waiting for the output register
  logic        res_granted;
  logic [3:0]  res_hole;
  logic        res_occ;
  logic [7:0]  res_owner;
  logic [15:0] res_cap;

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tail_done) begin
      res_granted <= probe_chain[HOLE_SLOTS].found;
      res_hole    <= probe_chain[HOLE_SLOTS].found ? 4'(best_idx_chain[HOLE_SLOTS]) : 4'd0;
      res_occ     <= probe_chain[HOLE_SLOTS].rd_occ;
      res_owner   <= 8'(owner_chain[HOLE_SLOTS]);
      // capacity is only reported for a read probe
      res_cap     <= probe_chain[HOLE_SLOTS].rd ? 16'(best_cap_chain[HOLE_SLOTS]) : 16'd0;
    end
  end

  // output register
  logic out_load;
  assign out_load = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      granted       <= res_granted;
      granted_hole  <= res_hole;
      read_occupied <= res_occ;
      read_owner    <= res_owner;
      read_capacity <= res_cap;
    end
  end

endmodule
